>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, codes and types of the fixed-partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;
    localparam int IDX_BITS       = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);

    // command codes
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // fit policies
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // result status
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // register indexes
    localparam logic REG_FIT_POLICY = 1'b0;

    // candidate travelling down the chain
    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] size;
    } probe_t;

    // broadcast table update from the controller
    typedef struct packed {
        logic                 add_en;
        logic                 alloc_en;
        logic                 release_en;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] amt;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell
// One partition entry; compares itself against the passing candidate.
// ----------------------------------------------------------------------------
module fpa_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fpa_pkg::IDX_BITS-1:0]  my_idx,
    input  fpa_pkg::cell_ctrl_t           ctrl,
    input  logic [fpa_pkg::SIZE_BITS-1:0] req_amt,
    input  logic [1:0]                    policy,
    input  fpa_pkg::probe_t               probe_in,
    output fpa_pkg::probe_t               probe_out
);

    logic [fpa_pkg::SIZE_BITS-1:0] size_reg;
    logic                          valid_reg;
    logic                          free_reg;
    fpa_pkg::probe_t               probe_reg;
    fpa_pkg::probe_t               probe_next;
    logic                          eligible;
    logic                          take;
    logic                          hit;

    assign hit      = (ctrl.idx == my_idx);
    assign eligible = valid_reg && free_reg && (size_reg >= req_amt);

    always_comb
    begin
        case (policy)
            fpa_pkg::POL_FIRST: take = eligible && !probe_in.found;
            fpa_pkg::POL_BEST:  take = eligible &&
                                       (!probe_in.found || (size_reg < probe_in.size));
            fpa_pkg::POL_WORST: take = eligible &&
                                       (!probe_in.found || (size_reg > probe_in.size));
            default:            take = 1'b0;
        endcase
        if (take)
        begin
            probe_next.found = 1'b1;
            probe_next.idx   = my_idx;
            probe_next.size  = size_reg;
        end
        else
        begin
            probe_next = probe_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            free_reg  <= 1'b1;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (ctrl.release_en)
            begin
                free_reg <= 1'b1;
            end
            else if (ctrl.add_en && hit)
            begin
                valid_reg <= 1'b1;
                free_reg  <= 1'b1;
            end
            else if (ctrl.alloc_en && hit)
            begin
                free_reg <= 1'b0;
            end
        end
    end

    // size holds no reset: read only once the entry is valid
    always_ff @(posedge clk)
    begin
        if (ctrl.add_en && hit)
        begin
            size_reg <= ctrl.amt;
        end
    end

    assign probe_out = probe_reg;

endmodule

>>> hw/rtl/fixed_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_partition_allocator_unit
// Fixed-partition allocator: a chain of partition cells searched by a
// travelling candidate, first/best/worst fit chosen by register.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transfer contents
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: amount
//  m_axis   | out       | tuser: status; tdata: slot, granted_size, leftover
//  apb      | in/out    | fit_policy at byte address 0
//
//  Add and release-all pass through accept and result; allocate passes
//  through accept, a scan in which the candidate walks the
//  cell chain one cell per cycle, and result. One command is worked on at a time; a
//  new command is taken while the previous result waits in the output
//  register. A stalled output holds the controller in its result state.
//  Reset empties the table and sets first fit; no clearing pass.
//
module fixed_partition_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] amount
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] slot, [19:4] granted_size,
                                   // [35:20] leftover, [39:36] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    localparam int N = fpa_pkg::MAX_PARTITIONS;

    state_t                        state_reg;
    state_t                        state_next;
    logic [1:0]                    policy_reg;
    logic [1:0]                    cmd_reg;
    logic [fpa_pkg::SIZE_BITS-1:0] amt_reg;
    logic [fpa_pkg::CNT_BITS-1:0]  count_reg;
    logic [fpa_pkg::IDX_BITS-1:0]  scan_cnt_reg;

    logic                          out_valid_reg;
    logic [1:0]                    status_reg;
    logic [3:0]                    slot_reg;
    logic [15:0]                   granted_reg;
    logic [15:0]                   leftover_reg;

    logic [1:0]                    status_next;
    logic [3:0]                    slot_next;
    logic [15:0]                   granted_next;
    logic [15:0]                   leftover_next;

    logic                          in_xfer;
    logic                          out_free;
    logic                          finish;
    logic                          table_full;
    logic                          scan_last;
    logic                          cfg_write;

    fpa_pkg::cell_ctrl_t           cell_ctrl;
    fpa_pkg::probe_t               probe_link [0:N];
    fpa_pkg::probe_t               result_probe;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == fpa_pkg::REG_FIT_POLICY) ? {30'd0, policy_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= fpa_pkg::POL_FIRST;
        end
        else if (cfg_write && (paddr[2] == fpa_pkg::REG_FIT_POLICY))
        begin
            policy_reg <= pwdata[1:0];
        end
    end

    // --------------------------------------------------------- controller
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign finish     = (state_reg == ST_RESULT) && out_free;
    assign table_full = (count_reg == fpa_pkg::CNT_BITS'(N));
    assign scan_last  = (scan_cnt_reg == fpa_pkg::IDX_BITS'(N - 1));
    assign result_probe = probe_link[N];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == fpa_pkg::CMD_ALLOC)
                        state_next = ST_SCAN;
                    else if (s_tuser == fpa_pkg::CMD_ADD || s_tuser == fpa_pkg::CMD_RELEASE)
                        state_next = ST_RESULT;
                    // unknown command: dropped, no result
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= fpa_pkg::CMD_ADD;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                cmd_reg      <= s_tuser;
                scan_cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cell_ctrl.add_en)
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            amt_reg <= fpa_pkg::SIZE_BITS'(s_tdata);
    end

    // result and table update, applied together on the finishing cycle
    always_comb
    begin
        status_next      = fpa_pkg::STATUS_OK;
        slot_next        = 4'd0;
        granted_next     = 16'd0;
        leftover_next    = 16'd0;
        cell_ctrl.add_en     = 1'b0;
        cell_ctrl.alloc_en   = 1'b0;
        cell_ctrl.release_en = 1'b0;
        cell_ctrl.idx        = fpa_pkg::IDX_BITS'(count_reg);
        cell_ctrl.amt        = amt_reg;
        case (cmd_reg)
            fpa_pkg::CMD_ADD:
            begin
                if (table_full)
                begin
                    status_next = fpa_pkg::STATUS_FULL;
                end
                else
                begin
                    slot_next        = 4'(count_reg);
                    cell_ctrl.add_en = finish;
                end
            end
            fpa_pkg::CMD_ALLOC:
            begin
                cell_ctrl.idx = result_probe.idx;
                if (result_probe.found)
                begin
                    slot_next          = 4'(result_probe.idx);
                    granted_next       = 16'(result_probe.size);
                    leftover_next      = 16'(result_probe.size - amt_reg);
                    cell_ctrl.alloc_en = finish;
                end
                else
                begin
                    status_next = fpa_pkg::STATUS_NOFIT;
                end
            end
            fpa_pkg::CMD_RELEASE:
            begin
                cell_ctrl.release_en = finish;
            end
            default:
            begin
                status_next = fpa_pkg::STATUS_OK;
            end
        endcase
    end

    // ----------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            granted_reg  <= granted_next;
            leftover_reg <= leftover_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'd0, leftover_reg, granted_reg, slot_reg};

    // ---------------------------------------------------------- cell chain
    // The candidate enters empty at the head and moves one cell per cycle.
    assign probe_link[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_idx    (fpa_pkg::IDX_BITS'(i)),
            .ctrl      (cell_ctrl),
            .req_amt   (amt_reg),
            .policy    (policy_reg),
            .probe_in  (probe_link[i]),
            .probe_out (probe_link[i+1])
        );
    end

endmodule

>>> tb/sv/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Watches the command, result and register channels of the fixed-partition
// allocator, keeps its own copy of the partition table and fit policy, and
// compares every result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module fpa_checker
    import fpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] amount
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [3:0] slot, [19:4] granted_size, [35:20] leftover
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FIT_POLICY_ADDR = 3'(4 * REG_FIT_POLICY);

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [15:0] granted;
        logic [15:0] leftover;
    } alloc_result_t;

    logic [SIZE_BITS-1:0] part_size_copy [MAX_PARTITIONS];
    bit                   part_free_copy [MAX_PARTITIONS];
    int unsigned          part_total;
    logic [1:0]           policy;
    alloc_result_t        awaited_results [$];

    // Applies one command to the table copy; returns 0 when the command
    // yields no result.
    function automatic bit serve_command(input logic [1:0] cmd, input logic [15:0] amt,
                                         output alloc_result_t res);
        bit          found;
        int unsigned pick;
        int unsigned i;
        found = 1'b0;
        pick  = 0;
        res   = '{STATUS_OK, 4'd0, 16'd0, 16'd0};
        case (cmd)
            CMD_ADD:
            begin
                if (part_total >= MAX_PARTITIONS)
                    res.status = STATUS_FULL;
                else
                begin
                    part_size_copy[part_total] = amt;
                    part_free_copy[part_total] = 1'b1;
                    res.slot   = 4'(part_total);
                    part_total = part_total + 1;
                end
                return 1'b1;
            end
            CMD_ALLOC:
            begin
                for (i = 0; i < part_total; i++)
                begin
                    if (part_free_copy[i] && part_size_copy[i] >= amt)
                    begin
                        case (policy)
                            POL_FIRST:
                                if (!found) begin found = 1'b1; pick = i; end
                            POL_BEST:
                                if (!found || part_size_copy[i] < part_size_copy[pick])
                                begin
                                    found = 1'b1;
                                    pick  = i;
                                end
                            POL_WORST:
                                if (!found || part_size_copy[i] > part_size_copy[pick])
                                begin
                                    found = 1'b1;
                                    pick  = i;
                                end
                            default: ;  // unused policy code never picks
                        endcase
                    end
                end
                if (!found)
                    res.status = STATUS_NOFIT;
                else
                begin
                    part_free_copy[pick] = 1'b0;
                    res.slot     = 4'(pick);
                    res.granted  = part_size_copy[pick];
                    res.leftover = part_size_copy[pick] - amt;
                end
                return 1'b1;
            end
            CMD_RELEASE:
            begin
                for (i = 0; i < MAX_PARTITIONS; i++)
                    part_free_copy[i] = 1'b1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t res;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PARTITIONS; k++)
            begin
                part_size_copy[k] = '0;
                part_free_copy[k] = 1'b1;
            end
            part_total = 0;
            policy     = POL_FIRST;
            awaited_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == FIT_POLICY_ADDR)
                policy = pwdata[1:0];
            if (s_tvalid && s_tready)
                if (serve_command(s_tuser, s_tdata, res))
                    awaited_results.push_back(res);
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    res = awaited_results.pop_front();
                    check_field("status", 16'(res.status), 16'(m_tuser));
                    check_field("slot", 16'(res.slot), 16'(m_tdata[3:0]));
                    check_field("granted_size", res.granted, m_tdata[19:4]);
                    check_field("leftover", res.leftover, m_tdata[35:20]);
                    check_field("tdata padding", 16'd0, 16'(m_tdata[39:36]));
                end
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for fixed_partition_allocator_unit: a directed table build and
// corner commands, then random allocate/release traffic under each fit
// policy, with random gaps on both streams and one long result back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    // Codes the package leaves unnamed: the spare command and policy values.
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [1:0] POL_UNUSED      = 2'd3;
    localparam logic [2:0] FIT_POLICY_ADDR = 3'(4 * REG_FIT_POLICY);

    localparam int ITEMS_PER_PHASE = 80;
    localparam int CYCLE_LIMIT     = 200000;
    // allocate walks the whole chain; allow a margin on top
    localparam int SETTLE_CYCLES   = MAX_PARTITIONS + 8;
    localparam int LONG_HOLD       = 400;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] amount
    logic [1:0]  s_tuser  = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [3:0] slot, [19:4] granted_size, [35:20] leftover
    logic [1:0]  m_tuser;         // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;

    // gaps on both streams; cleared for the last phase
    bit gaps_on   = 1'b1;
    // asks the result side for one long hold-off
    bit stall_req = 1'b0;

    // sizes added so far, used to aim allocate requests at the table
    logic [15:0] table_sizes [$];

    fixed_partition_allocator_unit u_dut (.*);

    fpa_checker u_checker (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit, well above the slowest legal run.
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fixed_partition_allocator_unit regression: fail");
        $finish;
    end

    // Result side: random ready bursts, plus the long hold-off on request.
    // During the hold the command side keeps offering, so the output
    // register and the controller fill and s_tready drops.
    initial
    begin
        forever
        begin
            if (stall_req)
            begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // One command transfer. tvalid stays high into the next call so that
    // back-to-back transfers leave no idle gap on the stream.
    task automatic send_command(input logic [1:0] cmd, input logic [15:0] amt);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= amt;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == CMD_ADD && table_sizes.size() < MAX_PARTITIONS)
            table_sizes.push_back(amt);
    endtask

    // Stops the command stream and waits for the block to go idle: all
    // results back, then enough cycles for an ignored command to drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_policy(input logic [1:0] pol);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FIT_POLICY_ADDR;
        pwdata  <= {30'd0, pol};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly requests near an existing size (exact fit, one under, one
    // over), the rest anywhere in the range.
    function automatic logic [15:0] pick_request();
        logic [15:0] base;
        if (table_sizes.size() == 0 || $urandom_range(0, 9) < 3)
            return 16'($urandom_range(0, 65535));
        base = table_sizes[$urandom_range(0, table_sizes.size() - 1)];
        return base + 16'($urandom_range(0, 2)) - 16'd1;
    endfunction

    // Random traffic: mostly allocates, releases often enough that the
    // free set keeps refilling, a few adds to the full table and a few
    // spare command codes (not counted, they produce nothing).
    task automatic random_command(output bit counted);
        int unsigned roll;
        roll    = $urandom_range(0, 99);
        counted = 1'b1;
        if (roll < 8)
            send_command(CMD_RELEASE, 16'($urandom));
        else if (roll < 13)
            send_command(CMD_ADD, 16'($urandom));
        else if (roll < 17)
        begin
            send_command(CMD_UNUSED, 16'($urandom));
            counted = 1'b0;
        end
        else
            send_command(CMD_ALLOC, pick_request());
    endtask

    initial
    begin
        logic [15:0] build_sizes [MAX_PARTITIONS];
        logic [1:0]  phase_policy [6];
        int  done;
        bit  counted;

        // sizes with ties, both extremes and a spread in between
        build_sizes = '{
            16'd0, 16'd65535, 16'd100, 16'd50, 16'd200, 16'd100, 16'd3000, 16'd50,
            16'd65535, 16'd1, 16'd4096, 16'd200, 16'd32768, 16'd7, 16'd1000, 16'd100};
        phase_policy = '{POL_BEST, POL_WORST, POL_UNUSED,
                         POL_FIRST, POL_BEST, POL_WORST};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, first fit from reset ---
        send_command(CMD_ALLOC, 16'd0);          // empty table: no fit
        send_command(CMD_RELEASE, 16'hFFFF);     // release on an empty table
        send_command(CMD_UNUSED, 16'h5A5A);      // spare code: no result
        foreach (build_sizes[k])
            send_command(CMD_ADD, build_sizes[k]);
        send_command(CMD_ADD, 16'h1234);         // table full
        send_command(CMD_ALLOC, 16'hFFFF);       // largest request
        send_command(CMD_ALLOC, 16'd0);          // zero request takes the zero-size slot
        send_command(CMD_ALLOC, 16'd101);
        send_command(CMD_RELEASE, 16'd0);

        // --- random phases, one policy each ---
        foreach (phase_policy[p])
        begin
            write_policy(phase_policy[p]);
            if (p == 5)
                gaps_on = 1'b0;                  // last phase runs without gaps
            send_command(CMD_RELEASE, 16'($urandom));
            done = 1;
            while (done < ITEMS_PER_PHASE)
            begin
                if (p == 2 && done == 10)
                    stall_req = 1'b1;            // long result hold-off mid-phase
                random_command(counted);
                if (counted)
                    done++;
            end
        end

        // back to the reset policy for a short closing run
        write_policy(POL_FIRST);
        send_command(CMD_RELEASE, 16'd0);
        repeat (20)
            send_command(CMD_ALLOC, pick_request());

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("fixed_partition_allocator_unit regression: pass");
        else
            $display("fixed_partition_allocator_unit regression: fail");
        $finish;
    end

endmodule
